>>> hdl/point_rotate_and_isometric_project_macros.svh
// Assertion macros for the point rotate / isometric projection block.
// Used by point_rotate_and_isometric_project.sv; expects clk_i and rst_ni in scope.
`ifndef POINT_ROTATE_AND_ISOMETRIC_PROJECT_MACROS_SVH
`define POINT_ROTATE_AND_ISOMETRIC_PROJECT_MACROS_SVH

// same-cycle implication
`define PRIP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define PRIP_ASSERT_DLY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

>>> hdl/prip_pkg.sv
// Shared constants and types for the point rotate / isometric projection block.
// No dependencies.
package prip_pkg;

  localparam int FRACTION_BITS_DEF = 8;
  localparam int COORD_WIDTH_DEF   = 32;

  localparam int CFG_WIDTH   = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int MODE_WIDTH  = 3;

  // coefficients: unsigned, 16 fraction bits, rounded to nearest
  localparam int K_BITS = 16;
  localparam logic [K_BITS-1:0] K_COS1  = 16'd65526;
  localparam logic [K_BITS-1:0] K_SIN1  = 16'd1144;
  localparam logic [K_BITS-1:0] K_ISO_X = 16'd52429;
  localparam logic [K_BITS-1:0] K_ISO_Y = 16'd19661;

  localparam logic [CFG_WIDTH-1:0] ROT_CX_RST  = 12'd160;
  localparam logic [CFG_WIDTH-1:0] ROT_CY_RST  = 12'd160;
  localparam logic [CFG_WIDTH-1:0] PROJ_OX_RST = 12'd290;
  localparam logic [CFG_WIDTH-1:0] PROJ_OY_RST = 12'd150;

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_TURN_POS = 3'd0,
    MODE_TURN_NEG = 3'd1,
    MODE_TILT_POS = 3'd2,
    MODE_TILT_NEG = 3'd3,
    MODE_PROJECT  = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_CX  = 2'd0,
    CFG_ROT_CY  = 2'd1,
    CFG_PROJ_OX = 2'd2,
    CFG_PROJ_OY = 2'd3
  } cfg_idx_e;

endpackage

>>> hdl/prip_mulr.sv
// Registered constant-coefficient multiply with round-half-up to the coordinate format.
// Depends on prip_pkg (coefficient width).
module prip_mulr #(
  parameter int AW = 34
) (
  input  logic                            clk_i,
  input  logic signed [AW-1:0]            a_i,
  input  logic [prip_pkg::K_BITS-1:0]     k_i,
  output logic signed [AW:0]              p_o
);
  import prip_pkg::*;

  localparam int PW = AW + K_BITS + 1;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd;
  logic signed [AW:0]   p_d;
  logic signed [AW:0]   p_q;

  always_comb begin
    prod = PW'(a_i) * PW'($signed({1'b0, k_i}));
    rnd  = prod + PW'(1 << (K_BITS - 1));
    p_d  = rnd[PW-1:K_BITS];
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

>>> hdl/point_rotate_and_isometric_project.sv
// Point rotate (vertical axis, about a center), tilt (x axis) and isometric projection.
// start reaches result_valid_o through the stage valid registers; one transaction accepted every cycle,
// busy stays low. Stages: operand register, four registered multipliers, sum/clamp.
// Async active-low reset clears the pipeline valids and loads the register defaults.
// Depends on prip_pkg, prip_mulr and point_rotate_and_isometric_project_macros.svh.
`include "point_rotate_and_isometric_project_macros.svh"

module point_rotate_and_isometric_project #(
  parameter int FRACTION_BITS = prip_pkg::FRACTION_BITS_DEF,
  parameter int COORD_WIDTH   = prip_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [prip_pkg::MODE_WIDTH-1:0]   mode_i,
  input  logic signed [COORD_WIDTH-1:0]     point_x_i,
  input  logic signed [COORD_WIDTH-1:0]     point_y_i,
  input  logic signed [COORD_WIDTH-1:0]     point_z_i,
  input  logic                              cfg_we_i,
  input  logic [prip_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [prip_pkg::CFG_WIDTH-1:0]    cfg_data_i,
  output logic                              result_valid_o,
  output logic signed [COORD_WIDTH-1:0]     result_x_o,
  output logic signed [COORD_WIDTH-1:0]     result_y_o,
  output logic signed [COORD_WIDTH-1:0]     result_z_o,
  output logic                              saturated_o
);
  import prip_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int CW   = CFG_WIDTH + FRACTION_BITS;
  localparam int BASE = (W > CW + 1) ? W : CW + 1;
  localparam int UW   = BASE + 2;
  localparam int RW   = UW + 1;
  localparam int SW   = RW + 2;

  localparam logic signed [W-1:0]  OUT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  OUT_MIN = ~OUT_MAX;
  localparam logic signed [SW-1:0] SUM_MAX = SW'(OUT_MAX);
  localparam logic signed [SW-1:0] SUM_MIN = SW'(OUT_MIN);

  typedef enum logic [1:0] {
    ROUTE_XY,
    ROUTE_YZ,
    ROUTE_PASS
  } route_e;

  logic accept;

  logic [CFG_WIDTH-1:0] rot_cx_q, rot_cy_q, proj_ox_q, proj_oy_q;

  // stage 1: operands
  logic                 s1_valid_q;
  route_e               s1_route_q, s1_route_d;
  logic signed [UW-1:0] s1_u_q [4];
  logic signed [UW-1:0] s1_u_d [4];
  logic [K_BITS-1:0]    s1_k0_q, s1_k0_d, s1_k1_q, s1_k1_d;
  logic signed [UW-1:0] s1_add_a_q, s1_add_a_d, s1_add_b_q, s1_add_b_d;
  logic signed [W-1:0]  s1_x_q, s1_y_q, s1_z_q;

  // stage 2: products
  logic                 s2_valid_q;
  route_e               s2_route_q;
  logic signed [RW-1:0] s2_p [4];
  logic signed [UW-1:0] s2_add_a_q, s2_add_b_q;
  logic signed [W-1:0]  s2_x_q, s2_y_q, s2_z_q;

  // stage 3: sums and clamp
  logic signed [SW-1:0] sum_a, sum_b;
  logic signed [SW-1:0] lane [3];
  logic [2:0]           over_hi, over_lo;
  logic signed [W-1:0]  lane_out [3];

  logic signed [UW-1:0] xe, ye, ze, cxe, cye, oxe, oye, dx, dy;
  logic                 neg;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_cx_q  <= ROT_CX_RST;
      rot_cy_q  <= ROT_CY_RST;
      proj_ox_q <= PROJ_OX_RST;
      proj_oy_q <= PROJ_OY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ROT_CX:  rot_cx_q  <= cfg_data_i;
        CFG_ROT_CY:  rot_cy_q  <= cfg_data_i;
        CFG_PROJ_OX: proj_ox_q <= cfg_data_i;
        CFG_PROJ_OY: proj_oy_q <= cfg_data_i;
        default:     rot_cx_q  <= rot_cx_q;
      endcase
    end
  end

  always_comb begin
    xe  = UW'(point_x_i);
    ye  = UW'(point_y_i);
    ze  = UW'(point_z_i);
    cxe = UW'(rot_cx_q) << FRACTION_BITS;
    cye = UW'(rot_cy_q) << FRACTION_BITS;
    oxe = UW'(proj_ox_q) << FRACTION_BITS;
    oye = UW'(proj_oy_q) << FRACTION_BITS;
    dx  = xe - cxe;
    dy  = ye - cye;
    neg = 1'b0;
    s1_u_d[0]  = '0;
    s1_u_d[1]  = '0;
    s1_u_d[2]  = '0;
    s1_u_d[3]  = '0;
    s1_k0_d    = K_COS1;
    s1_k1_d    = K_COS1;
    s1_add_a_d = '0;
    s1_add_b_d = '0;
    s1_route_d = ROUTE_PASS;
    unique case (mode_i)
      MODE_TURN_POS, MODE_TURN_NEG: begin
        neg        = (mode_i == MODE_TURN_NEG);
        s1_u_d[0]  = dx;
        s1_u_d[1]  = dy;
        s1_u_d[2]  = neg ? -dy : dy;
        s1_u_d[3]  = neg ? -dx : dx;
        s1_add_a_d = cxe;
        s1_add_b_d = cye;
        s1_route_d = ROUTE_XY;
      end
      MODE_TILT_POS, MODE_TILT_NEG: begin
        neg        = (mode_i == MODE_TILT_NEG);
        s1_u_d[0]  = ye;
        s1_u_d[1]  = ze;
        s1_u_d[2]  = neg ? -ze : ze;
        s1_u_d[3]  = neg ? -ye : ye;
        s1_route_d = ROUTE_YZ;
      end
      MODE_PROJECT: begin
        s1_u_d[0]  = xe - ye;
        s1_u_d[1]  = xe + ye;
        s1_k0_d    = K_ISO_X;
        s1_k1_d    = K_ISO_Y;
        s1_add_a_d = oxe;
        s1_add_b_d = oye - ze;
        s1_route_d = ROUTE_XY;
      end
      default: begin
        s1_route_d = ROUTE_PASS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      s2_valid_q     <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      s1_valid_q     <= accept;
      s2_valid_q     <= s1_valid_q;
      result_valid_o <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_u_q     <= s1_u_d;
      s1_k0_q    <= s1_k0_d;
      s1_k1_q    <= s1_k1_d;
      s1_add_a_q <= s1_add_a_d;
      s1_add_b_q <= s1_add_b_d;
      s1_route_q <= s1_route_d;
      s1_x_q     <= point_x_i;
      s1_y_q     <= point_y_i;
      s1_z_q     <= point_z_i;
    end
    s2_add_a_q <= s1_add_a_q;
    s2_add_b_q <= s1_add_b_q;
    s2_route_q <= s1_route_q;
    s2_x_q     <= s1_x_q;
    s2_y_q     <= s1_y_q;
    s2_z_q     <= s1_z_q;
  end

  prip_mulr #(.AW(UW)) u_mul0 (.clk_i(clk_i), .a_i(s1_u_q[0]), .k_i(s1_k0_q), .p_o(s2_p[0]));
  prip_mulr #(.AW(UW)) u_mul1 (.clk_i(clk_i), .a_i(s1_u_q[1]), .k_i(s1_k1_q), .p_o(s2_p[1]));
  prip_mulr #(.AW(UW)) u_mul2 (.clk_i(clk_i), .a_i(s1_u_q[2]), .k_i(K_SIN1), .p_o(s2_p[2]));
  prip_mulr #(.AW(UW)) u_mul3 (.clk_i(clk_i), .a_i(s1_u_q[3]), .k_i(K_SIN1), .p_o(s2_p[3]));

  always_comb begin
    sum_a = SW'(s2_p[0]) - SW'(s2_p[2]) + SW'(s2_add_a_q);
    sum_b = SW'(s2_p[3]) + SW'(s2_p[1]) + SW'(s2_add_b_q);
    unique case (s2_route_q)
      ROUTE_XY: begin
        lane[0] = sum_a;
        lane[1] = sum_b;
        lane[2] = SW'(s2_z_q);
      end
      ROUTE_YZ: begin
        lane[0] = SW'(s2_x_q);
        lane[1] = sum_a;
        lane[2] = sum_b;
      end
      default: begin
        lane[0] = SW'(s2_x_q);
        lane[1] = SW'(s2_y_q);
        lane[2] = SW'(s2_z_q);
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      over_hi[i] = lane[i] > SUM_MAX;
      over_lo[i] = lane[i] < SUM_MIN;
      if (over_hi[i]) begin
        lane_out[i] = OUT_MAX;
      end else if (over_lo[i]) begin
        lane_out[i] = OUT_MIN;
      end else begin
        lane_out[i] = lane[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    result_x_o  <= lane_out[0];
    result_y_o  <= lane_out[1];
    result_z_o  <= lane_out[2];
    saturated_o <= |{over_hi, over_lo};
  end

  `PRIP_ASSERT_DLY(a_latency, accept, 3, result_valid_o, "result strobe missing 3 cycles after start")
  `PRIP_ASSERT_IMPL(a_sat_extreme, result_valid_o && saturated_o, (result_x_o == OUT_MAX || result_x_o == OUT_MIN || result_y_o == OUT_MAX || result_y_o == OUT_MIN || result_z_o == OUT_MAX || result_z_o == OUT_MIN), "saturated flag without a clamped result")
  `PRIP_ASSERT_DLY(a_turn_keeps_z, accept && (mode_i == MODE_TURN_POS || mode_i == MODE_TURN_NEG), 3, result_z_o == $past(point_z_i, 3), "turn changed the height")

endmodule
